>>> design/bpa_pkg.sv
// bpa_pkg: types, codes and helper functions for the buddy page allocator
// no dependencies; used by the interfaces, controller, datapath, top level and checker

package bpa_pkg;

    // upper bound of the order parameter, sets the widths of the scan helpers
    localparam int ORDER_CAP = 18;
    localparam int SCAN_W    = ORDER_CAP + 1;
    localparam int KIDX_W    = 5;
    // wide enough for page + count checks at any legal pool size
    localparam int SUM_W     = 20;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_INSERT = 2'd2,
        OP_REMOVE = 2'd3
    } t_opcode;

    typedef logic [3:0]        t_order;
    typedef logic [9:0]        t_page;
    typedef logic [10:0]       t_count;
    typedef logic [1:0]        t_status;
    typedef logic [KIDX_W-1:0] t_kidx;

    localparam t_status ST_DONE = 2'd0;
    localparam t_status ST_OOM  = 2'd1;
    localparam t_status ST_BAD  = 2'd2;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD_REQ,
        DP_INIT_CLEAR,
        DP_INIT_WRITE,
        DP_INIT_ALLOC,
        DP_WRITE,
        DP_SCAN_START,
        DP_SCAN,
        DP_DECOMP,
        DP_RESULT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic bad;
        logic skip;
        logic is_alloc;
        logic run_end;
        logic scan_done;
        logic decomp_last;
        logic best_vld;
        logic write_last;
        logic out_free;
    } t_dp_sts;

    // index of the lowest set bit, all ones when none is set
    function automatic t_kidx f_low_one(input logic [SCAN_W-1:0] v);
        t_kidx idx;
        idx = '1;
        for (int i = SCAN_W - 1; i >= 0; i--) begin
            if (v[i]) idx = t_kidx'(i);
        end
        return idx;
    endfunction

    // index of the highest set bit
    function automatic t_kidx f_high_one(input logic [SCAN_W-1:0] v);
        t_kidx idx;
        idx = '0;
        for (int i = 0; i < SCAN_W; i++) begin
            if (v[i]) idx = t_kidx'(i);
        end
        return idx;
    endfunction

endpackage

>>> design/bpa_req_if.sv
// bpa_req_if: request channel of the buddy page allocator
// depends on bpa_pkg for the field types

interface bpa_req_if;
    logic             valid;
    logic             ready;
    bpa_pkg::t_opcode opcode;
    bpa_pkg::t_order  order;
    bpa_pkg::t_page   page_number;
    bpa_pkg::t_count  page_count;

    modport source (output valid, output opcode, output order, output page_number,
                    output page_count, input ready);
    modport sink   (input valid, input opcode, input order, input page_number,
                    input page_count, output ready);
endinterface

>>> design/bpa_rsp_if.sv
// bpa_rsp_if: result channel of the buddy page allocator
// depends on bpa_pkg for the field types

interface bpa_rsp_if;
    logic             valid;
    logic             ready;
    bpa_pkg::t_status status;
    bpa_pkg::t_page   granted_page;

    modport source (output valid, output status, output granted_page, input ready);
    modport sink   (input valid, input status, input granted_page, output ready);
endinterface

>>> design/bpa_ctrl.sv
// bpa_ctrl: sequencing state machine of the buddy page allocator
// depends on bpa_pkg; drives commands into bpa_dp and reads its status

module bpa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  bpa_pkg::t_dp_sts i_sts,
    output bpa_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [8:0] {
        S_INIT   = 9'b000000001,
        S_CLEAR  = 9'b000000010,
        S_IDLE   = 9'b000000100,
        S_DECIDE = 9'b000001000,
        S_SCAN   = 9'b000010000,
        S_DECOMP = 9'b000100000,
        S_ALLOC  = 9'b001000000,
        S_WRITE  = 9'b010000000,
        S_RESP   = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd.op    = bpa_pkg::DP_NONE;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.op = bpa_pkg::DP_INIT_CLEAR;
                n_state  = S_CLEAR;
            end
            S_CLEAR: begin
                o_cmd.op = bpa_pkg::DP_WRITE;
                if (i_sts.write_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.op = bpa_pkg::DP_LOAD_REQ;
                    n_state  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.bad || i_sts.skip) begin
                    n_state = S_RESP;
                end else if (i_sts.is_alloc) begin
                    o_cmd.op = bpa_pkg::DP_SCAN_START;
                    n_state  = S_SCAN;
                end else begin
                    o_cmd.op = bpa_pkg::DP_INIT_WRITE;
                    n_state  = S_WRITE;
                end
            end
            S_SCAN: begin
                o_cmd.op = bpa_pkg::DP_SCAN;
                if (i_sts.run_end) begin
                    n_state = S_DECOMP;
                end else if (i_sts.scan_done) begin
                    n_state = i_sts.best_vld ? S_ALLOC : S_RESP;
                end
            end
            S_DECOMP: begin
                o_cmd.op = bpa_pkg::DP_DECOMP;
                if (i_sts.decomp_last) n_state = S_SCAN;
            end
            S_ALLOC: begin
                o_cmd.op = bpa_pkg::DP_INIT_ALLOC;
                n_state  = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.op = bpa_pkg::DP_WRITE;
                if (i_sts.write_last) n_state = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.op = bpa_pkg::DP_RESULT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

endmodule

>>> design/bpa_dp.sv
// bpa_dp: datapath of the buddy page allocator: page free map, range writer,
// free-run scanner with block decomposition, result register; depends on bpa_pkg

module bpa_dp #(
    parameter int POOL_PAGES = 1024,
    parameter int TOP_ORDER  = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bpa_pkg::t_dp_cmd  i_cmd,
    output bpa_pkg::t_dp_sts  o_sts,
    input  bpa_pkg::t_opcode  i_opcode,
    input  bpa_pkg::t_order   i_order,
    input  bpa_pkg::t_page    i_page_number,
    input  bpa_pkg::t_count   i_page_count,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    output bpa_pkg::t_status  o_status,
    output bpa_pkg::t_page    o_granted_page
);

    localparam int AW    = $clog2(POOL_PAGES);
    localparam int PW    = $clog2(POOL_PAGES + 1);
    localparam int SUM_W = bpa_pkg::SUM_W;
    localparam int SCW   = bpa_pkg::SCAN_W;

    // one free flag per page
    logic mem [POOL_PAGES];
    logic r_rdata;

    bpa_pkg::t_opcode r_op;
    bpa_pkg::t_order  r_ord;
    bpa_pkg::t_page   r_page;
    bpa_pkg::t_count  r_cnt_in;

    logic [PW-1:0]  r_addr;
    logic [PW-1:0]  r_wcnt;
    logic           r_wval;
    logic           r_dvld;
    logic [PW-1:0]  r_dpage;
    logic           r_in_run;
    logic [PW-1:0]  r_run_a;
    logic [PW-1:0]  r_run_b;
    logic           r_best_vld;
    bpa_pkg::t_kidx r_best_k;
    logic [PW-1:0]  r_best_a;
    logic           r_out_vld;
    bpa_pkg::t_status r_out_st;
    bpa_pkg::t_page   r_out_pg;

    // argument checks
    logic             ord_big;
    logic [SUM_W-1:0] blk_sz;
    logic [SUM_W-1:0] pg_ext;
    logic [SUM_W-1:0] cnt_ext;
    logic [SUM_W-1:0] pool_ext;
    logic             free_bad;
    logic             rng_bad;
    logic             bad;
    logic             skip;

    // scan and decomposition
    logic             pool_end;
    logic             run_end;
    logic             scan_done;
    logic [PW-1:0]    run_b_val;
    logic [PW-1:0]    run_len;
    bpa_pkg::t_kidx   k_al;
    bpa_pkg::t_kidx   k_ln;
    bpa_pkg::t_kidx   k_min;
    bpa_pkg::t_kidx   k_blk;
    logic [PW-1:0]    a_next;
    logic             decomp_last;
    logic             take;
    logic             we;

    always_comb begin
        ord_big  = bpa_pkg::t_kidx'(r_ord) > bpa_pkg::t_kidx'(TOP_ORDER);
        blk_sz   = SUM_W'(1) << r_ord;
        pg_ext   = SUM_W'(r_page);
        cnt_ext  = SUM_W'(r_cnt_in);
        pool_ext = SUM_W'(POOL_PAGES);
        free_bad = ord_big || ((pg_ext & (blk_sz - SUM_W'(1))) != '0)
                   || (pg_ext + blk_sz > pool_ext);
        rng_bad  = (pg_ext + cnt_ext) > pool_ext;
        unique case (r_op)
            bpa_pkg::OP_ALLOC: bad = ord_big;
            bpa_pkg::OP_FREE:  bad = free_bad;
            default:           bad = rng_bad;
        endcase
        skip = (r_op == bpa_pkg::OP_INSERT || r_op == bpa_pkg::OP_REMOVE)
               && (r_cnt_in == '0);
    end

    always_comb begin
        pool_end  = r_addr == PW'(POOL_PAGES);
        run_end   = r_dvld ? (!r_rdata && r_in_run) : (pool_end && r_in_run);
        scan_done = !r_dvld && pool_end && !r_in_run;
        run_b_val = r_dvld ? r_dpage : PW'(POOL_PAGES);

        // largest aligned block at the run start that fits in the run
        run_len = r_run_b - r_run_a;
        k_al    = bpa_pkg::f_low_one(SCW'(r_run_a));
        k_ln    = bpa_pkg::f_high_one(SCW'(run_len));
        k_min   = (k_al < k_ln) ? k_al : k_ln;
        k_blk   = (k_min < bpa_pkg::t_kidx'(TOP_ORDER)) ? k_min
                                                        : bpa_pkg::t_kidx'(TOP_ORDER);
        a_next      = r_run_a + (PW'(1) << k_blk);
        decomp_last = a_next == r_run_b;
        // smallest fitting order wins, the lower address on a tie
        take = (k_blk >= bpa_pkg::t_kidx'(r_ord)) && (!r_best_vld || k_blk < r_best_k);
        we   = i_cmd.op == bpa_pkg::DP_WRITE;
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[r_addr[AW-1:0]] <= r_wval;
        r_rdata <= mem[r_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_dvld     <= 1'b0;
            r_in_run   <= 1'b0;
            r_best_vld <= 1'b0;
        end else begin
            // a new result may load in the cycle the old one transfers
            if (i_cmd.op == bpa_pkg::DP_RESULT) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && i_rsp_ready) begin
                r_out_vld <= 1'b0;
            end
            case (i_cmd.op)
                bpa_pkg::DP_LOAD_REQ: r_best_vld <= 1'b0;
                bpa_pkg::DP_SCAN_START: begin
                    r_dvld   <= 1'b0;
                    r_in_run <= 1'b0;
                end
                bpa_pkg::DP_SCAN: begin
                    if (run_end) begin
                        r_dvld <= 1'b0;
                    end else begin
                        r_dvld <= !pool_end;
                        if (r_dvld && r_rdata) r_in_run <= 1'b1;
                    end
                end
                bpa_pkg::DP_DECOMP: begin
                    if (take) r_best_vld <= 1'b1;
                    if (decomp_last) r_in_run <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            bpa_pkg::DP_LOAD_REQ: begin
                r_op     <= i_opcode;
                r_ord    <= i_order;
                r_page   <= i_page_number;
                r_cnt_in <= i_page_count;
            end
            bpa_pkg::DP_INIT_CLEAR: begin
                r_addr <= '0;
                r_wcnt <= PW'(POOL_PAGES);
                r_wval <= 1'b0;
            end
            bpa_pkg::DP_INIT_WRITE: begin
                r_addr <= PW'(r_page);
                r_wcnt <= (r_op == bpa_pkg::OP_FREE) ? PW'(blk_sz) : PW'(r_cnt_in);
                r_wval <= r_op != bpa_pkg::OP_REMOVE;
            end
            bpa_pkg::DP_INIT_ALLOC: begin
                r_addr <= r_best_a;
                r_wcnt <= PW'(blk_sz);
                r_wval <= 1'b0;
            end
            bpa_pkg::DP_WRITE: begin
                r_addr <= r_addr + PW'(1);
                r_wcnt <= r_wcnt - PW'(1);
            end
            bpa_pkg::DP_SCAN_START: r_addr <= '0;
            bpa_pkg::DP_SCAN: begin
                if (run_end) begin
                    r_run_b <= run_b_val;
                end else begin
                    if (!pool_end) begin
                        r_dpage <= r_addr;
                        r_addr  <= r_addr + PW'(1);
                    end
                    if (r_dvld && r_rdata && !r_in_run) r_run_a <= r_dpage;
                end
            end
            bpa_pkg::DP_DECOMP: begin
                r_run_a <= a_next;
                if (take) begin
                    r_best_k <= k_blk;
                    r_best_a <= r_run_a;
                end
            end
            bpa_pkg::DP_RESULT: begin
                if (bad) begin
                    r_out_st <= bpa_pkg::ST_BAD;
                end else if (r_op == bpa_pkg::OP_ALLOC && !r_best_vld) begin
                    r_out_st <= bpa_pkg::ST_OOM;
                end else begin
                    r_out_st <= bpa_pkg::ST_DONE;
                end
                r_out_pg <= (!bad && r_op == bpa_pkg::OP_ALLOC && r_best_vld)
                            ? bpa_pkg::t_page'(r_best_a) : '0;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_sts.bad         = bad;
        o_sts.skip        = skip;
        o_sts.is_alloc    = r_op == bpa_pkg::OP_ALLOC;
        o_sts.run_end     = run_end;
        o_sts.scan_done   = scan_done;
        o_sts.decomp_last = decomp_last;
        o_sts.best_vld    = r_best_vld;
        o_sts.write_last  = r_wcnt == PW'(1);
        o_sts.out_free    = !r_out_vld || i_rsp_ready;
    end

    assign o_rsp_valid    = r_out_vld;
    assign o_status       = r_out_st;
    assign o_granted_page = r_out_pg;

endmodule

>>> design/buddy_page_allocator.sv
// buddy_page_allocator: top level, binary buddy allocator over a page pool
// depends on bpa_pkg, bpa_req_if, bpa_rsp_if, bpa_ctrl and bpa_dp
//
//   channel  | dir | fields                                      | handshake
//   i_req    | in  | opcode, order, page_number, page_count      | valid/ready
//   o_rsp    | out | status, granted_page                         | valid/ready
//
// one request at a time; the free map holds one bit per page and is walked one page a cycle,
// pausing while each free run found is split into aligned blocks
// allocate: the whole map is scanned, then the granted block's pages are marked taken
// free, insert, remove: the pages named are written; bad or empty requests write nothing
// after reset a clearing pass over the whole map runs before the first request is taken
// a stalled result sits in the output register while the next request is taken

module buddy_page_allocator #(
    parameter int POOL_PAGES = 1024,
    parameter int TOP_ORDER  = 10
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bpa_req_if.sink   i_req,
    bpa_rsp_if.source o_rsp
);

    bpa_pkg::t_dp_cmd cmd;
    bpa_pkg::t_dp_sts sts;
    logic             req_ready;

    bpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bpa_dp #(
        .POOL_PAGES (POOL_PAGES),
        .TOP_ORDER  (TOP_ORDER)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_opcode       (i_req.opcode),
        .i_order        (i_req.order),
        .i_page_number  (i_req.page_number),
        .i_page_count   (i_req.page_count),
        .o_rsp_valid    (o_rsp.valid),
        .i_rsp_ready    (o_rsp.ready),
        .o_status       (o_rsp.status),
        .o_granted_page (o_rsp.granted_page)
    );

    assign i_req.ready = req_ready;

endmodule

>>> design/bpa_chk.sv
// bpa_chk: port-level checks for the buddy page allocator
// depends on bpa_pkg; bound onto buddy_page_allocator below

module bpa_chk (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_req_valid,
    input logic             i_req_ready,
    input logic             i_rsp_valid,
    input logic             i_rsp_ready,
    input bpa_pkg::t_status i_status,
    input bpa_pkg::t_page   i_granted
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_status) && $stable(i_granted))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_status == bpa_pkg::ST_DONE || i_status == bpa_pkg::ST_OOM
                         || i_status == bpa_pkg::ST_BAD))
        else $error("unknown status code");

    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_status != bpa_pkg::ST_DONE |-> i_granted == '0)
        else $error("granted page set on a failed request");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while one is in progress");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid after reset");

endmodule

bind buddy_page_allocator bpa_chk u_bpa_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_granted   (o_rsp.granted_page)
);

>>> bench/buddy_page_allocator_tb.sv
`timescale 1ns / 1ps
// buddy_page_allocator_tb: self-checking bench for the buddy page allocator
// depends on bpa_pkg, bpa_req_if, bpa_rsp_if and buddy_page_allocator

module buddy_page_allocator_tb;

    localparam int POOL  = 1024;
    localparam int TOPK  = 10;
    localparam int WDOG  = 20000;
    localparam int DRAIN = 3000;

    typedef struct {
        bpa_pkg::t_opcode opcode;
        bpa_pkg::t_order  order;
        bpa_pkg::t_page   page_number;
        bpa_pkg::t_count  page_count;
    } t_request;

    typedef struct {
        bpa_pkg::t_status status;
        bpa_pkg::t_page   granted_page;
    } t_reply;

    typedef struct {
        int page;
        int order;
    } t_block;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    bpa_req_if req_bus ();
    bpa_rsp_if rsp_bus ();

    buddy_page_allocator #(.POOL_PAGES(POOL), .TOP_ORDER(TOPK)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus.sink),
        .o_rsp   (rsp_bus.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_request pending_reqs[$];
    t_reply   expected_replies[$];
    t_block   granted_blocks[$];
    logic [POOL-1:0] page_is_free = '0;
    int error_count = 0;
    int idle_cycles = 0;

    function automatic bit span_free(int start, int size);
        for (int p = start; p < start + size; p++)
            if (!page_is_free[p]) return 1'b0;
        return 1'b1;
    endfunction

    // a block is listed free at order k when whole and its parent is not
    function automatic bit is_free_block(int k, int b);
        int first;
        first = b << k;
        if (!span_free(first, 1 << k)) return 1'b0;
        if (k == TOPK) return 1'b1;
        return !span_free((b >> 1) << (k + 1), 1 << (k + 1));
    endfunction

    function automatic t_reply predict_reply(t_request r);
        t_reply rep;
        int ord, pg, cnt, size;
        rep.status = bpa_pkg::ST_DONE;
        rep.granted_page = '0;
        ord = int'(r.order);
        pg  = int'(r.page_number);
        cnt = int'(r.page_count);
        case (r.opcode)
            bpa_pkg::OP_ALLOC: begin
                if (ord > TOPK) rep.status = bpa_pkg::ST_BAD;
                else begin
                    rep.status = bpa_pkg::ST_OOM;
                    for (int k = ord; k <= TOPK && rep.status == bpa_pkg::ST_OOM; k++)
                        for (int b = 0; b < (POOL >> k) && rep.status == bpa_pkg::ST_OOM;
                             b++)
                            if (is_free_block(k, b)) begin
                                rep.status = bpa_pkg::ST_DONE;
                                rep.granted_page = bpa_pkg::t_page'(b << k);
                            end
                    if (rep.status == bpa_pkg::ST_DONE) begin
                        for (int p = 0; p < (1 << ord); p++)
                            page_is_free[int'(rep.granted_page) + p] = 1'b0;
                        granted_blocks.push_back('{page: int'(rep.granted_page),
                                                   order: ord});
                    end
                end
            end
            bpa_pkg::OP_FREE: begin
                if (ord > TOPK) rep.status = bpa_pkg::ST_BAD;
                else begin
                    size = 1 << ord;
                    if ((pg & (size - 1)) != 0 || pg + size > POOL)
                        rep.status = bpa_pkg::ST_BAD;
                    else for (int p = pg; p < pg + size; p++) page_is_free[p] = 1'b1;
                end
            end
            default: begin
                if (pg + cnt > POOL) rep.status = bpa_pkg::ST_BAD;
                else for (int p = pg; p < pg + cnt; p++)
                    page_is_free[p] = (r.opcode == bpa_pkg::OP_INSERT);
            end
        endcase
        return rep;
    endfunction

    // sender: bursts of random length separated by random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid       <= 1'b0;
            req_bus.opcode      <= bpa_pkg::OP_ALLOC;
            req_bus.order       <= '0;
            req_bus.page_number <= '0;
            req_bus.page_count  <= '0;
        end else if (!(req_bus.valid && !req_bus.ready)) begin
            if (req_bus.valid) begin
                expected_replies.push_back(predict_reply(pending_reqs[0]));
                void'(pending_reqs.pop_front());
            end
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                req_bus.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                req_bus.valid       <= 1'b1;
                req_bus.opcode      <= pending_reqs[0].opcode;
                req_bus.order       <= pending_reqs[0].order;
                req_bus.page_number <= pending_reqs[0].page_number;
                req_bus.page_count  <= pending_reqs[0].page_count;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 12);
                    if ($urandom_range(0, 3) != 0) gap_left = $urandom_range(0, 40);
                end else begin
                    burst_left = burst_left - 1;
                end
            end else begin
                req_bus.valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern is re-chosen at random each time stall_tick wraps
    int stall_mode = 0;
    int stall_tick = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (expected_replies.size() == 0) begin
                    $error("result transfer with nothing expected");
                    error_count++;
                end else begin
                    if (rsp_bus.status !== expected_replies[0].status) begin
                        $error("status: expected %0d, got %0d",
                               expected_replies[0].status, rsp_bus.status);
                        error_count++;
                    end
                    if (rsp_bus.granted_page !== expected_replies[0].granted_page) begin
                        $error("granted_page: expected %0d, got %0d",
                               expected_replies[0].granted_page, rsp_bus.granted_page);
                        error_count++;
                    end
                    void'(expected_replies.pop_front());
                end
            end
            stall_tick++;
            if (stall_tick == 64) begin
                stall_tick = 0;
                stall_mode = $urandom_range(0, 3);
            end
            case (stall_mode)
                0:       rsp_bus.ready <= 1'b1;
                1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
                2:       rsp_bus.ready <= ($urandom_range(0, 7) == 0);
                default: rsp_bus.ready <= (stall_tick[4:0] < 5'd20);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WDOG) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic add_req(bpa_pkg::t_opcode op, int ord, int pg, int cnt);
        pending_reqs.push_back('{opcode: op, order: bpa_pkg::t_order'(ord),
                                 page_number: bpa_pkg::t_page'(pg),
                                 page_count: bpa_pkg::t_count'(cnt)});
    endtask

    function automatic int small_order();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 65) return $urandom_range(1, 2);
        if (r < 90) return $urandom_range(3, 6);
        return $urandom_range(7, TOPK);
    endfunction

    initial begin
        int sel, ord, pg, cnt, idx;
        // directed
        add_req(bpa_pkg::OP_ALLOC, 0, 0, 0);          // nothing free
        add_req(bpa_pkg::OP_ALLOC, 11, 0, 0);         // order too large
        add_req(bpa_pkg::OP_ALLOC, 15, 1023, 2047);
        add_req(bpa_pkg::OP_FREE, 15, 0, 0);
        add_req(bpa_pkg::OP_FREE, 3, 4, 0);           // misaligned
        add_req(bpa_pkg::OP_FREE, 1, 1023, 0);
        add_req(bpa_pkg::OP_INSERT, 0, 1000, 100);    // range past the pool
        add_req(bpa_pkg::OP_REMOVE, 0, 1023, 2);
        add_req(bpa_pkg::OP_INSERT, 0, 5, 0);         // empty range
        add_req(bpa_pkg::OP_INSERT, 0, 0, 1024);
        add_req(bpa_pkg::OP_ALLOC, 10, 0, 0);
        add_req(bpa_pkg::OP_ALLOC, 0, 0, 0);
        add_req(bpa_pkg::OP_FREE, 10, 0, 0);
        add_req(bpa_pkg::OP_ALLOC, 0, 0, 0);
        add_req(bpa_pkg::OP_ALLOC, 3, 0, 0);
        add_req(bpa_pkg::OP_FREE, 0, 1, 0);           // pages already free
        add_req(bpa_pkg::OP_FREE, 0, 0, 0);
        add_req(bpa_pkg::OP_REMOVE, 0, 100, 300);
        add_req(bpa_pkg::OP_REMOVE, 0, 150, 10);      // pages not free
        add_req(bpa_pkg::OP_ALLOC, 9, 0, 0);
        add_req(bpa_pkg::OP_INSERT, 0, 1023, 1);
        add_req(bpa_pkg::OP_REMOVE, 0, 0, 1024);
        add_req(bpa_pkg::OP_INSERT, 0, 0, 1024);
        // random, mostly well-formed
        for (int n = 0; n < 600; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 38) begin
                add_req(bpa_pkg::OP_ALLOC, small_order(), $urandom_range(0, 1023),
                        $urandom_range(0, 2047));
            end else if (sel < 62) begin
                if (granted_blocks.size() > 0 && $urandom_range(0, 3) != 0) begin
                    idx = $urandom_range(0, granted_blocks.size() - 1);
                    add_req(bpa_pkg::OP_FREE, granted_blocks[idx].order,
                            granted_blocks[idx].page, $urandom_range(0, 2047));
                    granted_blocks.delete(idx);
                end else begin
                    ord = small_order();
                    pg = ($urandom_range(0, 1023) >> ord) << ord;
                    add_req(bpa_pkg::OP_FREE, ord, pg, 0);
                end
            end else if (sel < 80) begin
                pg = $urandom_range(0, 1023);
                cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, POOL - pg)
                                                  : $urandom_range(0, 16);
                if (pg + cnt > POOL) cnt = POOL - pg;
                add_req(bpa_pkg::OP_INSERT, 0, pg, cnt);
            end else if (sel < 90) begin
                pg = $urandom_range(0, 1023);
                cnt = $urandom_range(0, 24);
                if (pg + cnt > POOL) cnt = POOL - pg;
                add_req(bpa_pkg::OP_REMOVE, 0, pg, cnt);
            end else begin
                add_req(bpa_pkg::t_opcode'($urandom_range(0, 3)), $urandom_range(0, 15),
                        $urandom_range(0, 1023), $urandom_range(0, 2047));
            end
        end
        granted_blocks.delete();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_reqs.size() == 0 && !req_bus.valid);
        wait (expected_replies.size() == 0);
        repeat (DRAIN) @(posedge i_clk);
        if (error_count == 0 && expected_replies.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
design/bpa_pkg.sv
design/bpa_req_if.sv
design/bpa_rsp_if.sv
design/bpa_ctrl.sv
design/bpa_dp.sv
design/buddy_page_allocator.sv
design/bpa_chk.sv
bench/buddy_page_allocator_tb.sv
